// ----- rtl/rsi_pkg.sv -----
// Package for the ray/sphere intersection block: widths, word types and register codes.
package rsi_pkg;

  localparam int CW = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int RADIUS_W = CW - 1;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);
  localparam int CFG_DATA_W = CW;

  localparam int DIG = 16;
  localparam int OMW = CW + 1;
  localparam int P1W = 2 * OMW;
  localparam int NPROD = 10;
  localparam int MS1 = (OMW + DIG - 1) / DIG;
  localparam int B1W = MS1 * DIG;

  localparam int AW = 2 * CW;
  localparam int HW = 2 * CW + 2;
  localparam int CCW = 2 * CW + 3;
  localparam int P2W = 2 * CCW;
  localparam int MS2 = (CCW + DIG - 1) / DIG;
  localparam int B2W = MS2 * DIG;
  localparam int DSW = 4 * CW + 4;
  localparam int DUW = 4 * CW + 3;

  typedef enum logic [1:0] {
    CFG_CENTER_X      = 2'd0,
    CFG_CENTER_Y      = 2'd1,
    CFG_CENTER_Z      = 2'd2,
    CFG_SPHERE_RADIUS = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic signed [CW-1:0] min_t;
    logic signed [CW-1:0] max_t;
  } ray_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] t_hit;
  } result_t;

endpackage

// ----- rtl/ray_sphere_intersect_top.sv -----
// Ray/sphere intersection: fully pipelined exact fixed-point quadratic solver.
//
//   channel   signals                         handshake
//   ray in    start, busy, ray                taken when start is high and busy is low
//   result    done, result                    one word per ray, valid for one cycle
//   config    cfg_we, cfg_index, cfg_data     written on any edge with cfg_we high
//
// A new ray is taken every cycle; busy is always low.
// The square root yields one root bit per stage over SW stages and each divider one
// quotient bit per stage over QW stages.
// Results leave in the order rays arrive. Reset clears all valid bits and restores
// the registers; the receiver cannot stall, so the pipeline never holds.
module ray_sphere_intersect_top #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  rsi_pkg::ray_t                        ray,
  output logic                                 done,
  output rsi_pkg::result_t                     result,
  input  logic                                 cfg_we,
  input  rsi_pkg::cfg_index_t                  cfg_index,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import rsi_pkg::*;

  localparam int NW = DUW + 2 * FRAC_BITS;
  localparam int SW = (NW + 1) / 2;
  localparam int NPW = 2 * SW;
  localparam int XW = HW + FRAC_BITS;
  localparam int QW = ((XW > SW + 1) ? XW : SW + 1) + 1;
  localparam int TW = QW + 2;

  // Configuration registers.
  logic signed [CW-1:0] center_x, center_y, center_z;
  logic [RADIUS_W-1:0]  sphere_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      sphere_radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X:      center_x      <= cfg_data;
        CFG_CENTER_Y:      center_y      <= cfg_data;
        CFG_CENTER_Z:      center_z      <= cfg_data;
        CFG_SPHERE_RADIUS: sphere_radius <= cfg_data[RADIUS_W-1:0];
      endcase
    end
  end

  assign busy = 1'b0;

  // Entry stage: origin relative to the centre.
  logic                  e1_v;
  logic signed [OMW-1:0] e1_od [6];
  logic [RADIUS_W-1:0]   e1_r;
  logic signed [CW-1:0]  e1_mn, e1_mx;

  always_ff @(posedge clk) begin
    e1_od[0] <= OMW'($signed(ray.origin_x)) - OMW'($signed(center_x));
    e1_od[1] <= OMW'($signed(ray.origin_y)) - OMW'($signed(center_y));
    e1_od[2] <= OMW'($signed(ray.origin_z)) - OMW'($signed(center_z));
    e1_od[3] <= OMW'($signed(ray.dir_x));
    e1_od[4] <= OMW'($signed(ray.dir_y));
    e1_od[5] <= OMW'($signed(ray.dir_z));
    e1_r     <= sphere_radius;
    e1_mn    <= ray.min_t;
    e1_mx    <= ray.max_t;
  end

  // First multiplier bank: ten products, one 16-bit digit per stage.
  logic [OMW-1:0] e1_mag [6];
  logic [5:0]     e1_sgn;
  logic [OMW-1:0] m1_ain [NPROD];
  logic [OMW-1:0] m1_bin [NPROD];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      e1_sgn[i] = e1_od[i][OMW-1];
      e1_mag[i] = e1_sgn[i] ? OMW'(-e1_od[i]) : OMW'(e1_od[i]);
    end
    for (int i = 0; i < 3; i++) begin
      m1_ain[i]     = e1_mag[3+i];
      m1_bin[i]     = e1_mag[3+i];
      m1_ain[3+i]   = e1_mag[i];
      m1_bin[3+i]   = e1_mag[3+i];
      m1_ain[6+i]   = e1_mag[i];
      m1_bin[6+i]   = e1_mag[i];
    end
    m1_ain[9] = OMW'(e1_r);
    m1_bin[9] = OMW'(e1_r);
  end

  logic                 m1_v  [MS1+1];
  logic [OMW-1:0]       m1_a  [MS1+1][NPROD];
  logic [B1W-1:0]       m1_b  [MS1+1][NPROD];
  logic [P1W-1:0]       m1_p  [MS1+1][NPROD];
  logic [2:0]           m1_hs [MS1+1];
  logic signed [CW-1:0] m1_mn [MS1+1];
  logic signed [CW-1:0] m1_mx [MS1+1];

  always_ff @(posedge clk) begin
    for (int j = 0; j < NPROD; j++) begin
      m1_a[0][j] <= m1_ain[j];
      m1_b[0][j] <= B1W'(m1_bin[j]);
      m1_p[0][j] <= '0;
    end
    m1_hs[0] <= e1_sgn[2:0] ^ e1_sgn[5:3];
    m1_mn[0] <= e1_mn;
    m1_mx[0] <= e1_mx;
    for (int k = 0; k < MS1; k++) begin
      for (int j = 0; j < NPROD; j++) begin
        m1_a[k+1][j] <= m1_a[k][j];
        m1_b[k+1][j] <= m1_b[k][j];
        m1_p[k+1][j] <= m1_p[k][j]
                        + (P1W'(m1_a[k][j] * m1_b[k][j][k*DIG +: DIG]) << (k * DIG));
      end
      m1_hs[k+1] <= m1_hs[k];
      m1_mn[k+1] <= m1_mn[k];
      m1_mx[k+1] <= m1_mx[k];
    end
  end

  // Sum stage: A = d.d, h = o.d, C = o.o - r*r.
  logic [AW-1:0]         s_a_next;
  logic signed [HW-1:0]  s_h_next;
  logic signed [CCW-1:0] s_c_next;
  logic signed [HW-1:0]  s_ht [3];

  always_comb begin
    s_a_next = AW'(m1_p[MS1][0]) + AW'(m1_p[MS1][1]) + AW'(m1_p[MS1][2]);
    for (int i = 0; i < 3; i++) begin
      s_ht[i] = HW'(m1_p[MS1][3+i]);
      if (m1_hs[MS1][i]) begin
        s_ht[i] = -s_ht[i];
      end
    end
    s_h_next = s_ht[0] + s_ht[1] + s_ht[2];
    s_c_next = CCW'(m1_p[MS1][6]) + CCW'(m1_p[MS1][7]) + CCW'(m1_p[MS1][8])
               - CCW'(m1_p[MS1][9]);
  end

  logic                  s_v;
  logic [AW-1:0]         s_a;
  logic signed [HW-1:0]  s_h;
  logic signed [CCW-1:0] s_c;
  logic signed [CW-1:0]  s_mn, s_mx;

  always_ff @(posedge clk) begin
    s_a  <= s_a_next;
    s_h  <= s_h_next;
    s_c  <= s_c_next;
    s_mn <= m1_mn[MS1];
    s_mx <= m1_mx[MS1];
  end

  // Second multiplier bank: h*h and A*|C|.
  logic signed [CCW-1:0] s_hx;
  logic [CCW-1:0]        s_hm, s_cm;

  always_comb begin
    s_hx = CCW'(s_h);
    s_hm = s_hx[CCW-1] ? CCW'(-s_hx) : CCW'(s_hx);
    s_cm = s_c[CCW-1] ? CCW'(-s_c) : CCW'(s_c);
  end

  logic                 m2_v    [MS2+1];
  logic [CCW-1:0]       m2_a    [MS2+1][2];
  logic [B2W-1:0]       m2_b    [MS2+1][2];
  logic [P2W-1:0]       m2_p    [MS2+1][2];
  logic                 m2_cneg [MS2+1];
  logic [AW-1:0]        m2_av   [MS2+1];
  logic signed [HW-1:0] m2_h    [MS2+1];
  logic signed [CW-1:0] m2_mn   [MS2+1];
  logic signed [CW-1:0] m2_mx   [MS2+1];

  always_ff @(posedge clk) begin
    m2_a[0][0]  <= s_hm;
    m2_b[0][0]  <= B2W'(s_hm);
    m2_a[0][1]  <= CCW'(s_a);
    m2_b[0][1]  <= B2W'(s_cm);
    m2_p[0][0]  <= '0;
    m2_p[0][1]  <= '0;
    m2_cneg[0]  <= s_c[CCW-1];
    m2_av[0]    <= s_a;
    m2_h[0]     <= s_h;
    m2_mn[0]    <= s_mn;
    m2_mx[0]    <= s_mx;
    for (int k = 0; k < MS2; k++) begin
      for (int j = 0; j < 2; j++) begin
        m2_a[k+1][j] <= m2_a[k][j];
        m2_b[k+1][j] <= m2_b[k][j];
        m2_p[k+1][j] <= m2_p[k][j]
                        + (P2W'(m2_a[k][j] * m2_b[k][j][k*DIG +: DIG]) << (k * DIG));
      end
      m2_cneg[k+1] <= m2_cneg[k];
      m2_av[k+1]   <= m2_av[k];
      m2_h[k+1]    <= m2_h[k];
      m2_mn[k+1]   <= m2_mn[k];
      m2_mx[k+1]   <= m2_mx[k];
    end
  end

  // Discriminant stage.
  logic signed [DSW-1:0] ds_d_next;
  logic signed [HW-1:0]  ds_hn;

  always_comb begin
    if (m2_cneg[MS2]) begin
      ds_d_next = DSW'(m2_p[MS2][0]) + DSW'(m2_p[MS2][1]);
    end else begin
      ds_d_next = DSW'(m2_p[MS2][0]) - DSW'(m2_p[MS2][1]);
    end
    ds_hn = -m2_h[MS2];
  end

  logic                 ds_v;
  logic [DUW-1:0]       ds_d;
  logic                 ds_miss;
  logic signed [XW-1:0] ds_x;
  logic [AW-1:0]        ds_a;
  logic signed [CW-1:0] ds_mn, ds_mx;

  always_ff @(posedge clk) begin
    ds_d    <= ds_d_next[DUW-1:0];
    ds_miss <= (m2_av[MS2] == '0) || ds_d_next[DSW-1];
    ds_x    <= XW'(ds_hn) <<< FRAC_BITS;
    ds_a    <= m2_av[MS2];
    ds_mn   <= m2_mn[MS2];
    ds_mx   <= m2_mx[MS2];
  end

  // Square root of D scaled by 2^(2*FRAC_BITS), one root bit per stage.
  logic                 sq_v    [SW+1];
  logic [NPW-1:0]       sq_n    [SW+1];
  logic [SW+1:0]        sq_rem  [SW+1];
  logic [SW-1:0]        sq_root [SW+1];
  logic                 sq_miss [SW+1];
  logic signed [XW-1:0] sq_x    [SW+1];
  logic [AW-1:0]        sq_a    [SW+1];
  logic signed [CW-1:0] sq_mn   [SW+1];
  logic signed [CW-1:0] sq_mx   [SW+1];
  logic [SW+1:0]        sq_rem2 [SW];
  logic [SW+1:0]        sq_try  [SW];
  logic                 sq_ge   [SW];

  always_comb begin
    for (int k = 0; k < SW; k++) begin
      sq_rem2[k] = {sq_rem[k][SW-1:0], sq_n[k][NPW-1 -: 2]};
      sq_try[k]  = {sq_root[k], 2'b01};
      sq_ge[k]   = sq_rem2[k] >= sq_try[k];
    end
  end

  always_ff @(posedge clk) begin
    sq_n[0]    <= NPW'(ds_d) << (2 * FRAC_BITS);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_miss[0] <= ds_miss;
    sq_x[0]    <= ds_x;
    sq_a[0]    <= ds_a;
    sq_mn[0]   <= ds_mn;
    sq_mx[0]   <= ds_mx;
    for (int k = 0; k < SW; k++) begin
      sq_n[k+1]    <= sq_n[k] << 2;
      sq_rem[k+1]  <= sq_ge[k] ? sq_rem2[k] - sq_try[k] : sq_rem2[k];
      sq_root[k+1] <= {sq_root[k][SW-2:0], sq_ge[k]};
      sq_miss[k+1] <= sq_miss[k];
      sq_x[k+1]    <= sq_x[k];
      sq_a[k+1]    <= sq_a[k];
      sq_mn[k+1]   <= sq_mn[k];
      sq_mx[k+1]   <= sq_mx[k];
    end
  end

  // Numerators X - floor(sqrt) and X + floor(sqrt).
  logic signed [QW-1:0] nm_xe, nm_se;

  always_comb begin
    nm_xe = QW'(sq_x[SW]);
    nm_se = QW'(sq_root[SW]);
  end

  logic                 nm_v;
  logic signed [QW-1:0] nm_n [2];
  logic                 nm_inex;
  logic                 nm_miss;
  logic [AW-1:0]        nm_a;
  logic signed [CW-1:0] nm_mn, nm_mx;

  always_ff @(posedge clk) begin
    nm_n[0]  <= nm_xe - nm_se;
    nm_n[1]  <= nm_xe + nm_se;
    nm_inex  <= sq_rem[SW] != '0;
    nm_miss  <= sq_miss[SW];
    nm_a     <= sq_a[SW];
    nm_mn    <= sq_mn[SW];
    nm_mx    <= sq_mx[SW];
  end

  // Two restoring dividers of magnitudes by A, one quotient bit per stage.
  logic                 dv_v    [QW+1];
  logic [QW-1:0]        dv_n    [QW+1][2];
  logic [AW-1:0]        dv_r    [QW+1][2];
  logic [QW-1:0]        dv_q    [QW+1][2];
  logic [1:0]           dv_neg  [QW+1];
  logic                 dv_inex [QW+1];
  logic                 dv_miss [QW+1];
  logic [AW-1:0]        dv_a    [QW+1];
  logic signed [CW-1:0] dv_mn   [QW+1];
  logic signed [CW-1:0] dv_mx   [QW+1];
  logic [AW:0]          dv_r2   [QW][2];
  logic                 dv_ge   [QW][2];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      for (int j = 0; j < 2; j++) begin
        dv_r2[k][j] = {dv_r[k][j], dv_n[k][j][QW-1]};
        dv_ge[k][j] = dv_r2[k][j] >= {1'b0, dv_a[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 2; j++) begin
      dv_n[0][j]  <= nm_n[j][QW-1] ? QW'(-nm_n[j]) : QW'(nm_n[j]);
      dv_r[0][j]  <= '0;
      dv_q[0][j]  <= '0;
      dv_neg[0][j] <= nm_n[j][QW-1];
    end
    dv_inex[0] <= nm_inex;
    dv_miss[0] <= nm_miss;
    dv_a[0]    <= nm_a;
    dv_mn[0]   <= nm_mn;
    dv_mx[0]   <= nm_mx;
    for (int k = 0; k < QW; k++) begin
      for (int j = 0; j < 2; j++) begin
        dv_n[k+1][j] <= dv_n[k][j] << 1;
        dv_r[k+1][j] <= dv_ge[k][j] ? AW'(dv_r2[k][j] - {1'b0, dv_a[k]})
                                    : AW'(dv_r2[k][j]);
        dv_q[k+1][j] <= {dv_q[k][j][QW-2:0], dv_ge[k][j]};
      end
      dv_neg[k+1]  <= dv_neg[k];
      dv_inex[k+1] <= dv_inex[k];
      dv_miss[k+1] <= dv_miss[k];
      dv_a[k+1]    <= dv_a[k];
      dv_mn[k+1]   <= dv_mn[k];
      dv_mx[k+1]   <= dv_mx[k];
    end
  end

  // Floor quotients.
  logic                 f1_v;
  logic signed [TW-1:0] f1_q [2];
  logic [1:0]           f1_rnz;
  logic                 f1_inex;
  logic                 f1_miss;
  logic signed [CW-1:0] f1_mn, f1_mx;
  logic signed [TW-1:0] f1_qe [2];
  logic [1:0]           f1_rnz_next;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      f1_rnz_next[j] = dv_r[QW][j] != '0;
      f1_qe[j] = TW'(dv_q[QW][j]) + TW'(f1_rnz_next[j]);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 2; j++) begin
      f1_q[j] <= dv_neg[QW][j] ? -f1_qe[j] : TW'(dv_q[QW][j]);
    end
    f1_rnz  <= f1_rnz_next;
    f1_inex <= dv_inex[QW];
    f1_miss <= dv_miss[QW];
    f1_mn   <= dv_mn[QW];
    f1_mx   <= dv_mx[QW];
  end

  // Floor and ceiling of both roots.
  logic                 f2_v;
  logic signed [TW-1:0] f2_nfl, f2_nce, f2_ffl, f2_fce;
  logic                 f2_miss;
  logic signed [CW-1:0] f2_mn, f2_mx;

  always_ff @(posedge clk) begin
    f2_nfl  <= f1_q[0] - TW'(f1_inex & ~f1_rnz[0]);
    f2_nce  <= f1_q[0] + TW'(f1_rnz[0]);
    f2_ffl  <= f1_q[1];
    f2_fce  <= f1_q[1] + TW'(f1_inex | f1_rnz[1]);
    f2_miss <= f1_miss;
    f2_mn   <= f1_mn;
    f2_mx   <= f1_mx;
  end

  // Interval test and root choice.
  logic signed [TW-1:0] fo_mn, fo_mx, fo_t;
  logic                 fo_hit;

  always_comb begin
    fo_mn  = TW'(f2_mn);
    fo_mx  = TW'(f2_mx);
    fo_hit = 1'b0;
    fo_t   = '0;
    if (!f2_miss && !(f2_nce > fo_mx) && !(f2_ffl < fo_mn)) begin
      if (f2_nfl >= fo_mn) begin
        fo_hit = 1'b1;
        fo_t   = f2_nfl[TW-1] ? f2_nce : f2_nfl;
      end else if (!(f2_fce > fo_mx)) begin
        fo_hit = 1'b1;
        fo_t   = f2_ffl[TW-1] ? f2_fce : f2_ffl;
      end
    end
  end

  always_ff @(posedge clk) begin
    result.hit   <= fo_hit;
    result.t_hit <= fo_t[CW-1:0];
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
      for (int k = 0; k <= MS1; k++) begin
        m1_v[k] <= 1'b0;
      end
      s_v <= 1'b0;
      for (int k = 0; k <= MS2; k++) begin
        m2_v[k] <= 1'b0;
      end
      ds_v <= 1'b0;
      for (int k = 0; k <= SW; k++) begin
        sq_v[k] <= 1'b0;
      end
      nm_v <= 1'b0;
      for (int k = 0; k <= QW; k++) begin
        dv_v[k] <= 1'b0;
      end
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      done <= 1'b0;
    end else begin
      e1_v    <= start & ~busy;
      m1_v[0] <= e1_v;
      for (int k = 0; k < MS1; k++) begin
        m1_v[k+1] <= m1_v[k];
      end
      s_v     <= m1_v[MS1];
      m2_v[0] <= s_v;
      for (int k = 0; k < MS2; k++) begin
        m2_v[k+1] <= m2_v[k];
      end
      ds_v    <= m2_v[MS2];
      sq_v[0] <= ds_v;
      for (int k = 0; k < SW; k++) begin
        sq_v[k+1] <= sq_v[k];
      end
      nm_v    <= sq_v[SW];
      dv_v[0] <= nm_v;
      for (int k = 0; k < QW; k++) begin
        dv_v[k+1] <= dv_v[k];
      end
      f1_v <= dv_v[QW];
      f2_v <= f1_v;
      done <= f2_v;
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Testbench for the ray/sphere intersection block: exact predictor, scoreboard and drivers.
`timescale 1ns / 100ps

module testbench;
  import rsi_pkg::*;

  typedef logic signed [255:0] wide_t;

  class sphere_hit_checker;
    logic signed [CW-1:0] cen_x, cen_y, cen_z;
    logic [RADIUS_W-1:0] radius;
    result_t pending_hits[$];
    int n_rays, n_hits, n_checked, n_errors;

    function new();
      cen_x = '0;
      cen_y = '0;
      cen_z = '0;
      radius = RADIUS_RESET;
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CENTER_X: cen_x = val;
        CFG_CENTER_Y: cen_y = val;
        CFG_CENTER_Z: cen_z = val;
        CFG_SPHERE_RADIUS: radius = val[RADIUS_W-1:0];
        default: ;
      endcase
    endfunction

    static function wide_t floor_div(wide_t n, wide_t a);
      wide_t q;
      q = n / a;
      if (n < 0 && (n % a) != 0) q = q - 1;
      return q;
    endfunction

    static function wide_t ceil_div(wide_t n, wide_t a);
      wide_t q;
      q = n / a;
      if (n > 0 && (n % a) != 0) q = q + 1;
      return q;
    endfunction

    function result_t trace_ray(ray_t r);
      wide_t ox, oy, oz, dx, dy, dz, qa, qh, qc, disc, n, sf, sc, cand, x, lo, hi;
      wide_t nfl, nce, ffl, fce, t;
      result_t res;
      res = '0;
      ox = wide_t'(r.origin_x) - wide_t'(cen_x);
      oy = wide_t'(r.origin_y) - wide_t'(cen_y);
      oz = wide_t'(r.origin_z) - wide_t'(cen_z);
      dx = wide_t'(r.dir_x);
      dy = wide_t'(r.dir_y);
      dz = wide_t'(r.dir_z);
      lo = wide_t'(r.min_t);
      hi = wide_t'(r.max_t);
      qa = dx * dx + dy * dy + dz * dz;
      qh = ox * dx + oy * dy + oz * dz;
      qc = ox * ox + oy * oy + oz * oz - wide_t'({1'b0, radius}) * wide_t'({1'b0, radius});
      disc = qh * qh - qa * qc;
      if (qa == 0 || disc < 0) return res;
      n = disc <<< (2 * FRAC_BITS_DEF);
      sf = 0;
      for (int b = 100; b >= 0; b--) begin
        cand = sf | (wide_t'(1) <<< b);
        if (cand * cand <= n) sf = cand;
      end
      sc = (sf * sf != n) ? sf + 1 : sf;
      x = (-qh) <<< FRAC_BITS_DEF;
      nfl = floor_div(x - sc, qa);
      nce = ceil_div(x - sf, qa);
      ffl = floor_div(x + sf, qa);
      fce = ceil_div(x + sc, qa);
      if (nce > hi || ffl < lo) return res;
      if (nfl >= lo) begin
        t = (nfl < 0) ? nce : nfl;
      end else begin
        if (fce > hi) return res;
        t = (ffl < 0) ? fce : ffl;
      end
      res.hit = 1'b1;
      res.t_hit = t[CW-1:0];
      return res;
    endfunction

    function void note_ray(ray_t r);
      pending_hits.push_back(trace_ray(r));
      n_rays++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_hits.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("Unexpected result word: hit=%0b t=%0d", got.hit, got.t_hit);
        return;
      end
      want = pending_hits.pop_front();
      n_checked++;
      if (want.hit) n_hits++;
      if (got.hit !== want.hit || got.t_hit !== want.t_hit) begin
        n_errors++;
        if (n_errors <= 10)
          $display("Mismatch on word %0d: expected hit=%0b t=%0d, got hit=%0b t=%0d",
                   n_checked, want.hit, want.t_hit, got.hit, got.t_hit);
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ray_t ray = '0;
  logic done;
  result_t result;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_CENTER_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sphere_hit_checker sb = new();
  int idle_cycles = 0;

  ray_sphere_intersect_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .ray(ray),
    .done(done), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_ray(ray);
      if (done) sb.check_result(result);
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("Watchdog expired with %0d words outstanding.", sb.pending_hits.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] near_value(logic [31:0] base, int span);
    return base + 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  task automatic send_ray(ray_t r, bit gaps);
    int gap;
    start <= 1'b1;
    ray <= r;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic end_burst();
    start <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_register(idx, val);
  endtask

  task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] rad);
    write_register(CFG_CENTER_X, cx);
    write_register(CFG_CENTER_Y, cy);
    write_register(CFG_CENTER_Z, cz);
    write_register(CFG_SPHERE_RADIUS, rad);
    cfg_we <= 1'b0;
  endtask

  function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                    int lo, int hi);
    ray_t r;
    r.origin_x = ox;
    r.origin_y = oy;
    r.origin_z = oz;
    r.dir_x = dx;
    r.dir_y = dy;
    r.dir_z = dz;
    r.min_t = lo;
    r.max_t = hi;
    return r;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return r;
  endfunction

  function automatic ray_t aimed_ray();
    ray_t r;
    int lo;
    r.origin_x = near_value(sb.cen_x, 1 << 21);
    r.origin_y = near_value(sb.cen_y, 1 << 21);
    r.origin_z = near_value(sb.cen_z, 1 << 21);
    r.dir_x = near_value(32'(sb.cen_x - r.origin_x) >>> 4, 1 << 15);
    r.dir_y = near_value(32'(sb.cen_y - r.origin_y) >>> 4, 1 << 15);
    r.dir_z = near_value(32'(sb.cen_z - r.origin_z) >>> 4, 1 << 15);
    lo = $urandom_range(0, 1 << 22) - (1 << 20);
    r.min_t = lo;
    r.max_t = lo + $urandom_range(0, 1 << 23) - (1 << 18);
    return r;
  endfunction

  task automatic random_burst(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 75) send_ray(aimed_ray(), 1'b1);
      else send_ray(noise_ray(), 1'b1);
    end
    end_burst();
  endtask

  localparam int ONE = 65536;
  localparam int MAXV = 32'h7fffffff;
  localparam int MINV = 32'h80000000;

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Unit sphere at the origin after reset.
    send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 0, 100 * ONE), 1'b0);
    send_ray(make_ray(0, 0, 0, 0, 0, ONE, 0, 100 * ONE), 1'b0);
    send_ray(make_ray(-5 * ONE, ONE, 0, ONE, 0, 0, 0, 100 * ONE), 1'b0);
    send_ray(make_ray(-5 * ONE, 0, 0, 0, 0, 0, MINV, MAXV), 1'b0);
    send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 10 * ONE, ONE), 1'b0);
    send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 0, 4 * ONE), 1'b0);
    send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 5 * ONE, 100 * ONE), 1'b0);
    send_ray(make_ray(5 * ONE, 0, 0, ONE, 0, 0, MINV, MAXV), 1'b0);
    send_ray(make_ray(-5 * ONE, 0, 0, 3, 7, -2, MINV, MAXV), 1'b0);
    send_ray(make_ray(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV), 1'b0);
    send_ray(make_ray(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV), 1'b0);
    send_ray(make_ray(MINV, 0, MAXV, 1, -1, MINV, MINV, MAXV), 1'b0);
    send_ray(make_ray(-1, -1, -1, -1, -1, -1, -1, -1), 1'b0);
    send_ray(make_ray(0, 0, 0, MAXV, 0, 0, 0, MAXV), 1'b0);
    end_burst();

    set_sphere(MAXV, MINV, MAXV, MAXV);
    send_ray(make_ray(MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV), 1'b0);
    send_ray(make_ray(0, 0, 0, MAXV, MINV, MAXV, MINV, MAXV), 1'b0);
    send_ray(make_ray(MAXV, MINV, MAXV, 1, 0, 0, MINV, MAXV), 1'b0);
    end_burst();

    set_sphere(MINV, MAXV, MINV, 0);
    send_ray(make_ray(MINV, MAXV - 3 * ONE, MINV, 0, ONE, 0, MINV, MAXV), 1'b0);
    send_ray(make_ray(MINV, MAXV, MINV, ONE, 0, 0, MINV, MAXV), 1'b0);
    end_burst();
    random_burst(60);

    set_sphere(0, 0, 0, ONE);
    random_burst(200);

    for (int k = 0; k < 5; k++) begin
      set_sphere(near_value(0, 1 << 24), near_value(0, 1 << 24), near_value(0, 1 << 24),
                 $urandom_range(0, 1 << 22));
      random_burst(100);
    end

    set_sphere($urandom, $urandom, $urandom, $urandom);
    random_burst(40);

    $display("Traced %0d rays over several sphere settings; %0d of %0d checked words were hits.",
             sb.n_rays, sb.n_hits, sb.n_checked);
    $display("Mismatches: %0d, words still expected: %0d.", sb.n_errors,
             sb.pending_hits.size());
    if (sb.n_errors == 0 && sb.pending_hits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
